// ----- design/dfs_pkg.sv -----
// Package for the depth-first path search unit: widths, codes, FSM state type.
// No dependencies.
package dfs_pkg;
   localparam int MAX_VERTICES_DEF = 16;
   localparam int MAX_DEGREE_DEF   = 8;
   localparam int CMD_W    = 2;
   localparam int VTX_W    = 4;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PATH    = 3'd0,
      ST_NOPATH  = 3'd1,
      ST_STORED  = 3'd2,
      ST_DROPPED = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_WAIT,
      S_STEP,
      S_EMIT,
      S_SINGLE
   } state_type;
endpackage

// ----- design/dfs_adj_store.sv -----
// Successor store: one memory of lists, per-vertex fill counts.
// Depends on dfs_pkg.
module dfs_adj_store #(
   parameter int NV = dfs_pkg::MAX_VERTICES_DEF,
   parameter int ND = dfs_pkg::MAX_DEGREE_DEF,
   localparam int VW = $clog2(NV),
   localparam int DW = $clog2(ND) > 0 ? $clog2(ND) : 1,
   localparam int CW = $clog2(ND + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic                      clr_en,
   input  logic [VW-1:0]             wr_vtx,
   input  logic [dfs_pkg::VTX_W-1:0] wr_data,
   input  logic [VW-1:0]             rd_vtx,
   input  logic [CW-1:0]             rd_idx,
   output logic [dfs_pkg::VTX_W-1:0] rd_data_ff,
   output logic [CW-1:0]             wr_count,
   output logic [CW-1:0]             rd_count
);
   logic [dfs_pkg::VTX_W-1:0] mem [NV*ND];
   logic [CW-1:0] count_ff [NV];

   assign wr_count = count_ff[wr_vtx];
   assign rd_count = count_ff[rd_vtx];

   // list memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[(NV*ND > 1 ? $clog2(NV*ND) : 1)'(int'(wr_vtx) * ND + int'(wr_count))] <= wr_data;
      rd_data_ff <= mem[(NV*ND > 1 ? $clog2(NV*ND) : 1)'(int'(rd_vtx) * ND + int'(rd_idx))];
   end

   // fill counts
   always_ff @(posedge clock) begin
      if (reset || clr_en) begin
         for (int i = 0; i < NV; i++) count_ff[i] <= '0;
      end else if (wr_en) begin
         count_ff[wr_vtx] <= wr_count + CW'(1);
      end
   end
endmodule

// ----- design/dfs_path_search_unit.sv -----
// Top level of the depth-first path search unit: sequencer, visited map, stack.
// Depends on dfs_pkg and dfs_adj_store.
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_command req_from_vertex req_to_vertex
//  rsp     | out       | rsp_valid rsp_ready rsp_status rsp_path_vertex rsp_last
// Edge add and clear: the result is registered at the transfer.
// Search: each edge tried passes fetch, wait (memory read latency in the walk loop)
// and step states; a backtrack pops in fetch; then one path vertex per rsp transfer.
// Reset is synchronous; fill counts and control clear at once.
// req_ready is low while a command is in flight; a stalled rsp holds path emission.
module dfs_path_search_unit #(
   parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF,
   parameter int MAX_DEGREE   = dfs_pkg::MAX_DEGREE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dfs_pkg::CMD_W-1:0]    req_command,
   input  logic [dfs_pkg::VTX_W-1:0]    req_from_vertex,
   input  logic [dfs_pkg::VTX_W-1:0]    req_to_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dfs_pkg::STATUS_W-1:0] rsp_status,
   output logic [dfs_pkg::VTX_W-1:0]    rsp_path_vertex,
   output logic                         rsp_last
);
   localparam int NV = MAX_VERTICES;
   localparam int VW = $clog2(NV);
   localparam int CW = $clog2(MAX_DEGREE + 1);
   localparam int SW = $clog2(NV + 1);
   localparam int XW = dfs_pkg::VTX_W;

   dfs_pkg::state_type state_ff, state_in;
   logic [XW-1:0] start_ff, goal_ff;
   logic [VW-1:0] stk_v_ff [NV];
   logic [CW-1:0] stk_i_ff [NV];
   logic [SW-1:0] depth_ff, depth_in, emit_ff, emit_in;
   logic [NV-1:0] visited_ff;
   logic rsp_valid_ff;
   logic [dfs_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [XW-1:0] rsp_vtx_ff;
   logic rsp_last_ff;

   logic out_free, accept, rsp_set;
   logic [VW-1:0] top_v, wr_vtx;
   logic [CW-1:0] top_i, wr_count, rd_count;
   logic [XW-1:0] rd_data;
   logic wr_en, clr_en, add_ok;
   logic [SW-1:0] top_ptr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == dfs_pkg::S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign top_ptr   = depth_ff - SW'(1);
   assign top_v     = stk_v_ff[top_ptr[VW-1:0]];
   assign top_i     = stk_i_ff[top_ptr[VW-1:0]];
   assign wr_vtx    = req_from_vertex[VW-1:0];
   assign add_ok    = (XW'(req_from_vertex) < XW'(NV) || NV > 15)
                      && (int'(req_to_vertex) < NV)
                      && (int'(req_from_vertex) < NV)
                      && (int'(wr_count) < MAX_DEGREE);
   assign wr_en  = accept && (req_command == dfs_pkg::CMD_ADD) && add_ok;
   assign clr_en = accept && (req_command == dfs_pkg::CMD_CLEAR);

   // result register loads on an edge/clear transfer, an emit step or a single-result step
   assign rsp_set = (accept && (req_command == dfs_pkg::CMD_ADD
                                || req_command == dfs_pkg::CMD_CLEAR))
                    || ((state_ff == dfs_pkg::S_EMIT || state_ff == dfs_pkg::S_SINGLE)
                        && out_free);

   dfs_adj_store #(.NV(NV), .ND(MAX_DEGREE)) u_store (
      .clock(clock), .reset(reset), .wr_en(wr_en), .clr_en(clr_en),
      .wr_vtx(wr_vtx), .wr_data(req_to_vertex), .rd_vtx(top_v), .rd_idx(top_i),
      .rd_data_ff(rd_data), .wr_count(wr_count), .rd_count(rd_count)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfs_pkg::S_IDLE:
            if (accept && req_command == dfs_pkg::CMD_SEARCH) begin
               if (req_from_vertex == req_to_vertex) state_in = dfs_pkg::S_SINGLE;
               else if (int'(req_from_vertex) >= NV || int'(req_to_vertex) >= NV)
                  state_in = dfs_pkg::S_SINGLE;
               else state_in = dfs_pkg::S_FETCH;
            end
         dfs_pkg::S_FETCH:
            if (depth_ff == '0) state_in = dfs_pkg::S_SINGLE;
            else if (top_i < rd_count && int'(top_i) < MAX_DEGREE) state_in = dfs_pkg::S_WAIT;
         dfs_pkg::S_WAIT: state_in = dfs_pkg::S_STEP;
         dfs_pkg::S_STEP:
            if (rd_data == goal_ff) state_in = dfs_pkg::S_EMIT;
            else state_in = dfs_pkg::S_FETCH;
         dfs_pkg::S_EMIT:
            if (out_free && emit_ff == depth_ff) state_in = dfs_pkg::S_IDLE;
         dfs_pkg::S_SINGLE:
            if (out_free) state_in = dfs_pkg::S_IDLE;
         default: state_in = dfs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      depth_in = depth_ff;
      emit_in  = emit_ff;
      case (state_ff)
         dfs_pkg::S_IDLE: begin
            depth_in = SW'(1);
            emit_in  = '0;
         end
         dfs_pkg::S_FETCH:
            if (depth_ff != '0 && !(top_i < rd_count && int'(top_i) < MAX_DEGREE))
               depth_in = depth_ff - SW'(1);
         dfs_pkg::S_STEP:
            if (rd_data != goal_ff && int'(rd_data) < NV && !visited_ff[rd_data[VW-1:0]]
                && int'(depth_ff) < NV)
               depth_in = depth_ff + SW'(1);
         dfs_pkg::S_EMIT:
            if (out_free) emit_in = emit_ff + SW'(1);
         default: ;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfs_pkg::S_IDLE;
         depth_ff     <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         visited_ff   <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         emit_ff  <= emit_in;
         if (rsp_set) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (accept) begin
            start_ff <= req_from_vertex;
            goal_ff  <= req_to_vertex;
            visited_ff <= NV'(1) << wr_vtx;
            stk_v_ff[0] <= wr_vtx;
            stk_i_ff[0] <= '0;
            if (req_command != dfs_pkg::CMD_SEARCH && req_command != dfs_pkg::CMD_NONE) begin
               rsp_vtx_ff    <= '0;
               rsp_last_ff   <= 1'b1;
               rsp_status_ff <= (req_command == dfs_pkg::CMD_CLEAR) ? dfs_pkg::ST_CLEARED
                                : (add_ok ? dfs_pkg::ST_STORED : dfs_pkg::ST_DROPPED);
            end
         end
         if (state_ff == dfs_pkg::S_WAIT)
            stk_i_ff[top_ptr[VW-1:0]] <= top_i + CW'(1);
         if (state_ff == dfs_pkg::S_STEP && rd_data != goal_ff && int'(rd_data) < NV
             && !visited_ff[rd_data[VW-1:0]] && int'(depth_ff) < NV) begin
            visited_ff[rd_data[VW-1:0]] <= 1'b1;
            stk_v_ff[depth_ff[VW-1:0]]  <= rd_data[VW-1:0];
            stk_i_ff[depth_ff[VW-1:0]]  <= '0;
         end
         if (state_ff == dfs_pkg::S_EMIT && out_free) begin
            rsp_status_ff <= dfs_pkg::ST_PATH;
            rsp_last_ff   <= (emit_ff == depth_ff);
            rsp_vtx_ff    <= (emit_ff == depth_ff) ? goal_ff
                             : XW'(stk_v_ff[emit_ff[VW-1:0]]);
         end
         if (state_ff == dfs_pkg::S_SINGLE && out_free) begin
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= (start_ff == goal_ff) ? dfs_pkg::ST_PATH : dfs_pkg::ST_NOPATH;
            rsp_vtx_ff    <= (start_ff == goal_ff) ? start_ff : '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_path_vertex = rsp_vtx_ff;
   assign rsp_last        = rsp_last_ff;
endmodule

// ----- design/dfs_checker.sv -----
// Port checker for the path search unit, bound to the top level.
// Depends on dfs_pkg.
module dfs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [dfs_pkg::STATUS_W-1:0] rsp_status,
   input logic [dfs_pkg::VTX_W-1:0]    rsp_path_vertex,
   input logic rsp_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)) else $error("rsp hold");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dfs_pkg::ST_PATH |-> rsp_path_vertex == '0 && rsp_last)
      else $error("non-path result");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready) else $error("ready during path");
   a_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_path_vertex) && $stable(rsp_last))
      else $error("rsp payload hold");
endmodule

bind dfs_path_search_unit dfs_checker u_chk (.*);
